>>> rtl/iscu_pkg.sv
// Shared types and constants for the integer string checker.
// No dependencies; every other file of the block but iscu_checker refers to this package.
package iscu_pkg;

  // Character codes used by the parser
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Largest magnitude that still takes another digit without overflow
  localparam logic [31:0] MAG_LIMIT = 32'd214748364;
  // Last digit allowed at MAG_LIMIT for each sign
  localparam logic [3:0] LAST_DIGIT_POS = 4'd7;
  localparam logic [3:0] LAST_DIGIT_NEG = 4'd8;

  localparam logic [7:0] COUNT_MAX       = 8'd255;
  localparam int         MAX_LEN_W       = 7;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 7'd12;

  // Parse phase
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_ENDED  = 3'd4,
    PH_BAD    = 3'd5
  } phase_t;

  // One input request as held in the input register
  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
    logic       empty_value;
  } iscu_item_t;

  // Per-string parse state
  typedef struct packed {
    phase_t      phase;
    logic [31:0] magnitude;
    logic        negative;
    logic [7:0]  char_count;
    logic        digit_seen;
    logic        range_error;
    logic [7:0]  first_bad;
  } iscu_state_t;

  localparam iscu_state_t STATE_CLEAR = '{
    phase:       PH_LEAD,
    magnitude:   32'd0,
    negative:    1'b0,
    char_count:  8'd0,
    digit_seen:  1'b0,
    range_error: 1'b0,
    first_bad:   8'd0
  };

  // One result request
  typedef struct packed {
    logic               error;
    logic               too_long;
    logic               bad_character;
    logic               no_digits;
    logic               out_of_range;
    logic [7:0]         bad_offset;
    logic signed [31:0] parsed_value;
  } iscu_result_t;

endpackage

>>> rtl/iscu_if.sv
// Valid/ready channel interfaces for the integer string checker.
// Depends on iscu_pkg for the configuration width.

// Input channel: one character request
interface iscu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;
  logic       empty_value;

  modport source (output valid, character, last_char, empty_value, input ready);
  modport sink   (input valid, character, last_char, empty_value, output ready);
endinterface

// Result channel: one status request per string
interface iscu_out_if;
  logic               valid;
  logic               ready;
  logic               error;
  logic               too_long;
  logic               bad_character;
  logic               no_digits;
  logic               out_of_range;
  logic [7:0]         bad_offset;
  logic signed [31:0] parsed_value;

  modport source (output valid, error, too_long, bad_character, no_digits, out_of_range,
                  bad_offset, parsed_value, input ready);
  modport sink   (input valid, error, too_long, bad_character, no_digits, out_of_range,
                  bad_offset, parsed_value, output ready);
endinterface

// Configuration write channel: max_length
interface iscu_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [iscu_pkg::MAX_LEN_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/integer_string_checker_unit.sv
// Top level of the decimal integer string checker.
// Depends on iscu_pkg, iscu_if, iscu_parser and iscu_out_stage.

// The checker takes one character request per clock unless a last character
// stalls, and gives one result request on the character marked last_char. A
// result passes the input register, then the result register. Throughput is
// set by the parse state update, which is combinational: a non-last character
// never waits, and a last character waits only while the result register holds
// an untaken result. max_length resets to 12; the user must write it through
// the cfg channel while the block is idle; the block does not enforce it.
module integer_string_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  iscu_in_if.sink    in_ch,
  iscu_out_if.source out_ch,
  iscu_cfg_if.sink   cfg_ch
);

  logic                           s1_valid_r;
  iscu_pkg::iscu_item_t           s1_item_r;
  logic [iscu_pkg::MAX_LEN_W-1:0] max_length_r;
  logic                           s1_go, slot_free;
  iscu_pkg::iscu_result_t         result;

  // Configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= iscu_pkg::MAX_LEN_RESET;
    end else if (cfg_ch.valid) begin
      max_length_r <= cfg_ch.data;
    end
  end

  // Input register advances unless a last character meets a full result slot
  assign s1_go       = s1_valid_r && (!s1_item_r.last_char || slot_free);
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= '{character:   in_ch.character,
                     last_char:   in_ch.last_char,
                     empty_value: in_ch.empty_value};
    end
  end

  iscu_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (s1_go),
    .item       (s1_item_r),
    .max_length (max_length_r),
    .result     (result)
  );

  iscu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_go && s1_item_r.last_char),
    .result    (result),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/iscu_parser.sv
// Parse state registers and the combinational character update.
// Depends on iscu_pkg; instantiated by integer_string_checker_unit.
module iscu_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  iscu_pkg::iscu_item_t           item,
  input  logic [iscu_pkg::MAX_LEN_W-1:0] max_length,
  output iscu_pkg::iscu_result_t         result
);

  iscu_pkg::iscu_state_t st_r, st_nxt, upd;
  logic        sp, dig, ovf, take_dig;
  logic [3:0]  d, lim;
  logic [31:0] mag_x10;
  logic [7:0]  count_inc;

  // Character classification and digit arithmetic
  always_comb begin
    sp      = (item.character == iscu_pkg::CH_SPACE);
    dig     = (item.character >= iscu_pkg::CH_ZERO) && (item.character <= iscu_pkg::CH_NINE);
    d       = item.character[3:0];
    lim     = st_r.negative ? iscu_pkg::LAST_DIGIT_NEG : iscu_pkg::LAST_DIGIT_POS;
    ovf     = (st_r.magnitude > iscu_pkg::MAG_LIMIT) ||
              ((st_r.magnitude == iscu_pkg::MAG_LIMIT) && (d > lim));
    mag_x10 = {st_r.magnitude[28:0], 3'b000} + {st_r.magnitude[30:0], 1'b0} + {28'd0, d};
    count_inc = (st_r.char_count < iscu_pkg::COUNT_MAX) ? st_r.char_count + 8'd1
                                                        : st_r.char_count;
  end

  // Phase update for one character
  always_comb begin
    upd      = st_r;
    take_dig = 1'b0;
    if (!item.empty_value) begin
      upd.char_count = count_inc;
      if (!(st_r.range_error || st_r.phase == iscu_pkg::PH_ENDED ||
            st_r.phase == iscu_pkg::PH_BAD)) begin
        if (item.character == iscu_pkg::CH_NUL) begin
          upd.phase = iscu_pkg::PH_ENDED;
        end else begin
          unique case (st_r.phase) inside
            iscu_pkg::PH_LEAD: begin
              if (sp) begin
                upd.phase = iscu_pkg::PH_LEAD;
              end else if (item.character == iscu_pkg::CH_PLUS ||
                           item.character == iscu_pkg::CH_MINUS) begin
                upd.negative = (item.character == iscu_pkg::CH_MINUS);
                upd.phase    = iscu_pkg::PH_SIGNED;
              end else if (dig) begin
                take_dig = 1'b1;
              end else begin
                upd.phase     = iscu_pkg::PH_BAD;
                upd.first_bad = count_inc;
              end
            end
            iscu_pkg::PH_SIGNED, iscu_pkg::PH_DIGITS: begin
              if (dig) begin
                take_dig = 1'b1;
              end else if (sp) begin
                upd.phase = iscu_pkg::PH_TRAIL;
              end else begin
                upd.phase     = iscu_pkg::PH_BAD;
                upd.first_bad = count_inc;
              end
            end
            default: begin
              // trailing spaces
              if (!sp) begin
                upd.phase     = iscu_pkg::PH_BAD;
                upd.first_bad = count_inc;
              end
            end
          endcase
          // accumulate the digit or flag the range overflow
          if (take_dig) begin
            upd.phase      = iscu_pkg::PH_DIGITS;
            upd.digit_seen = 1'b1;
            if (ovf) begin
              upd.range_error = 1'b1;
            end else begin
              upd.magnitude = mag_x10;
            end
          end
        end
      end
    end
  end

  // Result on the last character; state clears after each string
  always_comb begin
    result = '0;
    st_nxt = upd;
    if (item.last_char) begin
      st_nxt = iscu_pkg::STATE_CLEAR;
      if (!item.empty_value) begin
        result.too_long = (upd.char_count > {1'b0, max_length});
        if (max_length != '0) begin
          if (upd.range_error) begin
            result.out_of_range = 1'b1;
          end else begin
            result.bad_character = (upd.phase == iscu_pkg::PH_BAD);
            result.bad_offset    = upd.first_bad;
            result.no_digits     = !upd.digit_seen;
            result.parsed_value  = upd.negative ? -$signed(upd.magnitude)
                                                : $signed(upd.magnitude);
          end
        end
        result.error = result.too_long | result.bad_character |
                       result.no_digits | result.out_of_range;
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= iscu_pkg::STATE_CLEAR;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> rtl/iscu_out_stage.sv
// Result register with valid/ready toward the result channel.
// Depends on iscu_pkg and iscu_out_if; instantiated by the top level.
module iscu_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  iscu_pkg::iscu_result_t result,
  output logic                   slot_free,
  iscu_out_if.source             out_ch
);

  logic                   valid_r;
  iscu_pkg::iscu_result_t data_r;

  // Free when empty or when the held request leaves this cycle
  assign slot_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.error         = data_r.error;
  assign out_ch.too_long      = data_r.too_long;
  assign out_ch.bad_character = data_r.bad_character;
  assign out_ch.no_digits     = data_r.no_digits;
  assign out_ch.out_of_range  = data_r.out_of_range;
  assign out_ch.bad_offset    = data_r.bad_offset;
  assign out_ch.parsed_value  = data_r.parsed_value;

endmodule

>>> rtl/iscu_checker.sv
// Port-level assertions for integer_string_checker_unit, with its bind.
// Depends only on the top level's result channel ports.
module iscu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        error,
  input logic        too_long,
  input logic        bad_character,
  input logic        no_digits,
  input logic        out_of_range,
  input logic [7:0]  bad_offset,
  input logic [31:0] parsed_value
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(parsed_value) && $stable(error))
    else $error("result changed while stalled");

  // Status is the OR of the four flags
  a_error_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> error == (too_long | bad_character | no_digits | out_of_range))
    else $error("error flag disagrees with flags");

  // Overflow suppresses the later checks and the value
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> !bad_character && !no_digits &&
                                  bad_offset == 8'd0 && parsed_value == 32'd0)
    else $error("overflow result carries other fields");

  // An offset is reported exactly when a bad character is
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> bad_character == (bad_offset != 8'd0))
    else $error("bad offset disagrees with bad character flag");

endmodule

bind integer_string_checker_unit iscu_checker u_iscu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .error         (out_ch.error),
  .too_long      (out_ch.too_long),
  .bad_character (out_ch.bad_character),
  .no_digits     (out_ch.no_digits),
  .out_of_range  (out_ch.out_of_range),
  .bad_offset    (out_ch.bad_offset),
  .parsed_value  (out_ch.parsed_value)
);
